// File: hdl/dlas_pkg.sv
// ----------------------------------------------------------------------------
// Lock acquisition sequencer package
// Shared word types, field widths and the status, event and command codes.
// ----------------------------------------------------------------------------
package dlas_pkg;

    // Field widths.
    localparam int FreqWidth   = 20;
    localparam int MhzWidth    = 11;
    localparam int StatusWidth = 4;
    localparam int EventWidth  = 2;
    localparam int CmdWidth    = 3;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 3;

    // Frequency conversion: kHz / 1000 as a multiply by a rounded-up
    // reciprocal. The error term stays below one LSB for any 20-bit input.
    localparam int                   KhzPerMhz   = 1000;
    localparam int                   MhzShift    = 29;
    localparam logic [FreqWidth-1:0] MhzRecip    =
        FreqWidth'(((64'd1 << MhzShift) + KhzPerMhz - 1) / KhzPerMhz);
    localparam logic [FreqWidth-1:0] DefaultKhz  = FreqWidth'(474000);
    localparam logic [MhzWidth-1:0]  DefaultMhz  = MhzWidth'(474000 / KhzPerMhz);

    // Operation codes of an input word.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Status codes.
    localparam logic [StatusWidth-1:0] ST_IDLE     = 4'd0;
    localparam logic [StatusWidth-1:0] ST_SCAN     = 4'd1;
    localparam logic [StatusWidth-1:0] ST_PLAY     = 4'd2;
    localparam logic [StatusWidth-1:0] ST_GI420    = 4'd3;
    localparam logic [StatusWidth-1:0] ST_GI945    = 4'd4;
    localparam logic [StatusWidth-1:0] ST_AUTOWAIT = 4'd5;
    localparam logic [StatusWidth-1:0] ST_LOCKED   = 4'd6;
    localparam logic [StatusWidth-1:0] ST_MANUAL   = 4'd7;
    localparam logic [StatusWidth-1:0] ST_UNLOCKED = 4'd8;

    // Notify events.
    localparam logic [EventWidth-1:0] EV_NONE     = 2'd0;
    localparam logic [EventWidth-1:0] EV_LOCKED   = 2'd1;
    localparam logic [EventWidth-1:0] EV_WAIT     = 2'd2;
    localparam logic [EventWidth-1:0] EV_UNLOCKED = 2'd3;

    // Demodulator commands.
    localparam logic [CmdWidth-1:0] CMD_NONE        = 3'd0;
    localparam logic [CmdWidth-1:0] CMD_TUNE_SCAN   = 3'd1;
    localparam logic [CmdWidth-1:0] CMD_TUNE_MANUAL = 3'd2;
    localparam logic [CmdWidth-1:0] CMD_AUTO_RESET  = 3'd3;
    localparam logic [CmdWidth-1:0] CMD_MANUAL      = 3'd4;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_AUTO_WAIT_LIMIT    = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_GUARD_TRIAL_LIMIT  = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_MANUAL_CHECK_TICKS = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_UNLOCK_THRESHOLD   = 3'd3;

    // Input word.
    typedef struct packed {
        logic                 op;
        logic [FreqWidth-1:0] freq_khz;
        logic                 force_play;
        logic                 req_guard_945;
        logic                 auto_done;
        logic                 demod_locked;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [StatusWidth-1:0] status;
        logic [EventWidth-1:0]  event_res;
        logic [CmdWidth-1:0]    command;
        logic [MhzWidth-1:0]    tune_mhz;
        logic                   cmd_guard_945;
    } out_word_t;

    // Configuration registers as seen by the sequencer core.
    typedef struct packed {
        logic [2:0] auto_wait_limit;
        logic [1:0] guard_trial_limit;
        logic [2:0] manual_check_ticks;
        logic [2:0] unlock_threshold;
    } cfg_regs_t;

endpackage

// File: hdl/dlas_core.sv
// ----------------------------------------------------------------------------
// Lock acquisition sequencer core
// Holds the acquisition state and computes one step of it for each word.
// ----------------------------------------------------------------------------
module dlas_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  dlas_pkg::in_word_t  item,
    input  dlas_pkg::cfg_regs_t cfg,
    output dlas_pkg::out_word_t result
);

    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_SCAN     = 4'd1,
        S_PLAY     = 4'd2,
        S_GI420    = 4'd3,
        S_GI945    = 4'd4,
        S_AUTOWAIT = 4'd5,
        S_LOCKED   = 4'd6,
        S_MANUAL   = 4'd7,
        S_UNLOCKED = 4'd8
    } state_t;

    state_t                          state_reg, state_next;
    logic                            pending_reg, pending_next;
    logic                            pend_force_reg, pend_force_next;
    logic                            req_guard_reg, req_guard_next;
    logic                            active_guard_reg, active_guard_next;
    logic [dlas_pkg::MhzWidth-1:0]   tuned_mhz_reg, tuned_mhz_next;
    logic [2:0]                      auto_wait_reg, auto_wait_next;
    logic [1:0]                      guard_try_reg, guard_try_next;
    logic [2:0]                      check_tick_reg, check_tick_next;
    logic [2:0]                      unlock_tick_reg, unlock_tick_next;

    logic [2*dlas_pkg::FreqWidth-1:0] freq_product;
    logic [dlas_pkg::MhzWidth-1:0]    freq_mhz;
    logic [dlas_pkg::EventWidth-1:0]  ev;
    logic [dlas_pkg::CmdWidth-1:0]    cmd;
    logic [dlas_pkg::MhzWidth-1:0]    mhz;
    logic                             gsel;

    // Request frequency in MHz through the reciprocal multiply.
    assign freq_product = {{dlas_pkg::FreqWidth{1'b0}}, item.freq_khz}
                        * {{dlas_pkg::FreqWidth{1'b0}}, dlas_pkg::MhzRecip};
    assign freq_mhz     = freq_product[dlas_pkg::MhzShift +: dlas_pkg::MhzWidth];

    // One step of the acquisition sequence.
    always_comb begin
        state_next        = state_reg;
        pending_next      = pending_reg;
        pend_force_next   = pend_force_reg;
        req_guard_next    = req_guard_reg;
        active_guard_next = active_guard_reg;
        tuned_mhz_next    = tuned_mhz_reg;
        auto_wait_next    = auto_wait_reg;
        guard_try_next    = guard_try_reg;
        check_tick_next   = check_tick_reg;
        unlock_tick_next  = unlock_tick_reg;
        ev   = dlas_pkg::EV_NONE;
        cmd  = dlas_pkg::CMD_NONE;
        mhz  = '0;
        gsel = 1'b0;

        if (item.op == dlas_pkg::OP_REQUEST) begin
            tuned_mhz_next  = freq_mhz;
            pend_force_next = item.force_play;
            req_guard_next  = item.req_guard_945;
            pending_next    = 1'b1;
        end else begin
            // A pending start takes effect before the step itself.
            if (pending_reg) begin
                state_next        = pend_force_reg ? S_PLAY : S_SCAN;
                active_guard_next = req_guard_reg;
                pending_next      = 1'b0;
            end

            case (state_next)
                S_SCAN: begin
                    cmd            = dlas_pkg::CMD_TUNE_SCAN;
                    mhz            = tuned_mhz_reg;
                    guard_try_next = '0;
                    auto_wait_next = cfg.auto_wait_limit;
                    state_next     = S_AUTOWAIT;
                    ev             = dlas_pkg::EV_WAIT;
                end
                S_PLAY: begin
                    cmd              = dlas_pkg::CMD_TUNE_MANUAL;
                    mhz              = tuned_mhz_reg;
                    gsel             = active_guard_next;
                    guard_try_next   = '0;
                    auto_wait_next   = '0;
                    check_tick_next  = '0;
                    unlock_tick_next = '0;
                    state_next       = S_MANUAL;
                end
                S_GI420, S_GI945: begin
                    active_guard_next = (state_next == S_GI945);
                    cmd               = dlas_pkg::CMD_AUTO_RESET;
                    gsel              = active_guard_next;
                    auto_wait_next    = '0;
                    state_next        = S_AUTOWAIT;
                end
                S_AUTOWAIT: begin
                    if (item.auto_done && item.demod_locked) begin
                        cmd              = dlas_pkg::CMD_MANUAL;
                        gsel             = active_guard_next;
                        check_tick_next  = '0;
                        unlock_tick_next = '0;
                        state_next       = S_MANUAL;
                    end else begin
                        ev = dlas_pkg::EV_WAIT;
                    end
                end
                S_LOCKED: begin
                    if (!item.demod_locked) begin
                        state_next       = S_MANUAL;
                        check_tick_next  = '0;
                        unlock_tick_next = '0;
                    end
                end
                S_MANUAL, S_UNLOCKED: begin
                    if (!item.demod_locked) begin
                        state_next       = S_MANUAL;
                        unlock_tick_next = unlock_tick_reg + 3'd1;
                    end
                    check_tick_next = check_tick_reg + 3'd1;
                    // End of the check window decides lock or renewed search.
                    if (check_tick_next >= cfg.manual_check_ticks) begin
                        if (unlock_tick_next >= cfg.unlock_threshold) begin
                            ev             = dlas_pkg::EV_WAIT;
                            state_next     = S_AUTOWAIT;
                            auto_wait_next = cfg.auto_wait_limit;
                        end else begin
                            ev = dlas_pkg::EV_LOCKED;
                        end
                        check_tick_next  = '0;
                        unlock_tick_next = '0;
                    end
                end
                default: begin
                end
            endcase

            // Event resolution: lock entry, wait counting and guard trials.
            if (ev == dlas_pkg::EV_LOCKED) begin
                auto_wait_next = '0;
                guard_try_next = '0;
                state_next     = S_LOCKED;
            end else if (ev == dlas_pkg::EV_WAIT && state_next == S_AUTOWAIT) begin
                if (auto_wait_next < cfg.auto_wait_limit) begin
                    auto_wait_next = auto_wait_next + 3'd1;
                    ev             = dlas_pkg::EV_NONE;
                end else begin
                    auto_wait_next = '0;
                    state_next     = guard_try_next[0] ? S_GI420 : S_GI945;
                    if (guard_try_next < cfg.guard_trial_limit) begin
                        guard_try_next = guard_try_next + 2'd1;
                        ev             = dlas_pkg::EV_NONE;
                    end else begin
                        guard_try_next = '0;
                        ev             = dlas_pkg::EV_UNLOCKED;
                    end
                end
            end
        end
    end

    // Result of the current word; only meaningful for a tick.
    assign result.status        = state_next;
    assign result.event_res     = ev;
    assign result.command       = cmd;
    assign result.tune_mhz      = mhz;
    assign result.cmd_guard_945 = gsel;

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            pending_reg      <= 1'b0;
            pend_force_reg   <= 1'b0;
            req_guard_reg    <= 1'b0;
            active_guard_reg <= 1'b0;
            tuned_mhz_reg    <= dlas_pkg::DefaultMhz;
            auto_wait_reg    <= '0;
            guard_try_reg    <= '0;
            check_tick_reg   <= '0;
            unlock_tick_reg  <= '0;
        end else if (step) begin
            state_reg        <= state_next;
            pending_reg      <= pending_next;
            pend_force_reg   <= pend_force_next;
            req_guard_reg    <= req_guard_next;
            active_guard_reg <= active_guard_next;
            tuned_mhz_reg    <= tuned_mhz_next;
            auto_wait_reg    <= auto_wait_next;
            guard_try_reg    <= guard_try_next;
            check_tick_reg   <= check_tick_next;
            unlock_tick_reg  <= unlock_tick_next;
        end
    end

`ifndef SYNTH
    // A pending start is always consumed by the next tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == dlas_pkg::OP_TICK |=> !pending_reg)
        else $error("pending start survived a tick");

    // A request never changes the sequencer status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.op == dlas_pkg::OP_REQUEST |=> $stable(state_reg))
        else $error("request changed the status");
`endif

endmodule

// File: hdl/demod_lock_acquisition_sequencer.sv
// ----------------------------------------------------------------------------
// Demodulator lock acquisition sequencer
// Input register, sequencer core and result register with config registers.
// ----------------------------------------------------------------------------
// Path: a tick word passes the input register, then the result register.
// Throughput: one word per cycle, set by the single-pass core step, as
// long as the receiver takes results without stalling.
// A request word updates state and gives no result.
// Reset: synchronous, active low; the sequencer returns to idle, the
// frequency to 474 MHz and the configuration registers to their defaults.
module demod_lock_acquisition_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dlas_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dlas_pkg::out_word_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlas_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [dlas_pkg::CfgDataWidth-1:0]   cfg_data
);

    logic                 in_valid_reg, in_valid_next;
    dlas_pkg::in_word_t   in_word_reg;
    logic                 out_valid_reg, out_valid_next;
    dlas_pkg::out_word_t  out_word_reg;
    dlas_pkg::out_word_t  core_result;
    dlas_pkg::cfg_regs_t  cfg_reg, cfg_next;
    logic                 advance;
    logic                 is_tick;

    // A held word advances when it gives no result or the result slot frees.
    assign is_tick   = (in_word_reg.op == dlas_pkg::OP_TICK);
    assign advance   = in_valid_reg && (!is_tick || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;

    always_comb begin
        in_valid_next = s_valid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && is_tick) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                dlas_pkg::CFG_AUTO_WAIT_LIMIT:    cfg_next.auto_wait_limit    = cfg_data;
                dlas_pkg::CFG_GUARD_TRIAL_LIMIT:  cfg_next.guard_trial_limit  = cfg_data[1:0];
                dlas_pkg::CFG_MANUAL_CHECK_TICKS: cfg_next.manual_check_ticks = cfg_data;
                dlas_pkg::CFG_UNLOCK_THRESHOLD:   cfg_next.unlock_threshold   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer step between the two registers.
    dlas_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_word_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{auto_wait_limit: 3'd3, guard_trial_limit: 2'd2,
                               manual_check_ticks: 3'd4, unlock_threshold: 3'd1};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance && is_tick) begin
            out_word_reg <= core_result;
        end
    end

`ifndef SYNTH
    // Every tick that leaves the input register shows up as a result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_tick |=> out_valid_reg)
        else $error("tick produced no result word");

    // A request never fills an empty result slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !is_tick && !(out_valid_reg && !m_ready) |=> !out_valid_reg)
        else $error("request produced a result word");

    // Only tune commands carry a frequency.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.command != dlas_pkg::CMD_TUNE_SCAN
            && m_data.command != dlas_pkg::CMD_TUNE_MANUAL |-> m_data.tune_mhz == '0)
        else $error("frequency on a non-tune command");

    // The locked event always comes with the locked status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_res == dlas_pkg::EV_LOCKED
            |-> m_data.status == dlas_pkg::ST_LOCKED)
        else $error("locked event without locked status");
`endif

endmodule

// File: tb/tb_demod_lock_acquisition_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lock acquisition sequencer testbench
// Drives tuning requests and periodic ticks into the sequencer and checks
// every status word against a cycle-free model of the acquisition state
// machine. The run covers directed corner cases and random acquisition
// sessions under several register settings, random idling on both
// channels, one long receiver hold-off and one sender pause.
// ----------------------------------------------------------------------------
module tb_demod_lock_acquisition_sequencer;

    import dlas_pkg::*;

    localparam int ClkHalf    = 2;
    localparam int ResetCycles = 12;
    localparam int IdleLimit  = 3000;
    localparam int HoldCycles = 400;
    localparam int SettleCycles = 4;
    // Index past the last register; writes to it must change nothing.
    localparam logic [CfgIdxWidth-1:0] CfgSpareIdx = 3'd6;

    // Model of the sequencer: register copies, state, and the queue of
    // status words still to come out of the block.
    class lock_seq_scoreboard;
        logic [2:0]             cfg_wait;
        logic [1:0]             cfg_trials;
        logic [2:0]             cfg_check;
        logic [2:0]             cfg_thresh;
        logic [StatusWidth-1:0] status;
        logic                   start_pend;
        logic                   pend_force;
        logic [FreqWidth-1:0]   freq_khz;
        logic                   req_guard;
        logic                   act_guard;
        logic [2:0]             wait_cnt;
        logic [1:0]             guard_try;
        logic [2:0]             chk_cnt;
        logic [2:0]             unl_cnt;
        out_word_t              pending_reports[$];
        int                     errors;

        function new();
            cfg_wait   = 3'd3;
            cfg_trials = 2'd2;
            cfg_check  = 3'd4;
            cfg_thresh = 3'd1;
            status     = ST_IDLE;
            start_pend = 1'b0;
            pend_force = 1'b0;
            freq_khz   = DefaultKhz;
            req_guard  = 1'b0;
            act_guard  = 1'b0;
            wait_cnt   = '0;
            guard_try  = '0;
            chk_cnt    = '0;
            unl_cnt    = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
            case (idx)
                CFG_AUTO_WAIT_LIMIT:    cfg_wait   = val;
                CFG_GUARD_TRIAL_LIMIT:  cfg_trials = val[1:0];
                CFG_MANUAL_CHECK_TICKS: cfg_check  = val;
                CFG_UNLOCK_THRESHOLD:   cfg_thresh = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // Advance the model by one accepted input word.
        function void note_word(in_word_t w);
            out_word_t             res;
            logic [EventWidth-1:0] ev;
            logic [CmdWidth-1:0]   cmd;
            logic [MhzWidth-1:0]   mhz;
            logic                  gsel;
            logic                  lk;
            if (w.op == OP_REQUEST) begin
                freq_khz   = w.freq_khz;
                pend_force = w.force_play;
                req_guard  = w.req_guard_945;
                start_pend = 1'b1;
                return;
            end
            ev   = EV_NONE;
            cmd  = CMD_NONE;
            mhz  = '0;
            gsel = 1'b0;
            lk   = w.demod_locked;

            // A stored request takes effect at the next tick.
            if (start_pend) begin
                status     = pend_force ? ST_PLAY : ST_SCAN;
                act_guard  = req_guard;
                start_pend = 1'b0;
            end

            case (status)
                ST_SCAN: begin
                    cmd       = CMD_TUNE_SCAN;
                    mhz       = MhzWidth'(freq_khz / KhzPerMhz);
                    guard_try = '0;
                    wait_cnt  = cfg_wait;
                    status    = ST_AUTOWAIT;
                    ev        = EV_WAIT;
                end
                ST_PLAY: begin
                    cmd       = CMD_TUNE_MANUAL;
                    mhz       = MhzWidth'(freq_khz / KhzPerMhz);
                    gsel      = act_guard;
                    guard_try = '0;
                    wait_cnt  = '0;
                    chk_cnt   = '0;
                    unl_cnt   = '0;
                    status    = ST_MANUAL;
                end
                ST_GI420, ST_GI945: begin
                    act_guard = (status == ST_GI945);
                    cmd       = CMD_AUTO_RESET;
                    gsel      = act_guard;
                    wait_cnt  = '0;
                    status    = ST_AUTOWAIT;
                end
                ST_AUTOWAIT: begin
                    if (w.auto_done && lk) begin
                        cmd     = CMD_MANUAL;
                        gsel    = act_guard;
                        chk_cnt = '0;
                        unl_cnt = '0;
                        status  = ST_MANUAL;
                    end else begin
                        ev = EV_WAIT;
                    end
                end
                ST_LOCKED: begin
                    if (!lk) begin
                        status  = ST_MANUAL;
                        chk_cnt = '0;
                        unl_cnt = '0;
                    end
                end
                ST_MANUAL, ST_UNLOCKED: begin
                    if (!lk) begin
                        status  = ST_MANUAL;
                        unl_cnt = unl_cnt + 3'd1;
                    end
                    chk_cnt = chk_cnt + 3'd1;
                    // End of a check window decides between lock and a
                    // fresh round of auto detection.
                    if (chk_cnt >= cfg_check) begin
                        if (unl_cnt >= cfg_thresh) begin
                            ev       = EV_WAIT;
                            status   = ST_AUTOWAIT;
                            wait_cnt = cfg_wait;
                        end else begin
                            ev = EV_LOCKED;
                        end
                        chk_cnt = '0;
                        unl_cnt = '0;
                    end
                end
                default: ;
            endcase

            // Resolve the event: lock, or count up the wait and step
            // through the guard-interval trials.
            if (ev == EV_LOCKED) begin
                wait_cnt  = '0;
                guard_try = '0;
                status    = ST_LOCKED;
            end else if (ev == EV_WAIT && status == ST_AUTOWAIT) begin
                if (wait_cnt < cfg_wait) begin
                    wait_cnt = wait_cnt + 3'd1;
                    ev       = EV_NONE;
                end else begin
                    wait_cnt = '0;
                    status   = guard_try[0] ? ST_GI420 : ST_GI945;
                    if (guard_try < cfg_trials) begin
                        guard_try = guard_try + 2'd1;
                        ev        = EV_NONE;
                    end else begin
                        guard_try = '0;
                        ev        = EV_UNLOCKED;
                    end
                end
            end

            res.status        = status;
            res.event_res     = ev;
            res.command       = cmd;
            res.tune_mhz      = mhz;
            res.cmd_guard_945 = gsel;
            pending_reports.push_back(res);
        endfunction

        function void cmp_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one status word from the block with the oldest prediction.
        function void check_report(out_word_t got);
            out_word_t want;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            cmp_field("status", want.status, got.status);
            cmp_field("event_res", want.event_res, got.event_res);
            cmp_field("command", want.command, got.command);
            cmp_field("tune_mhz", want.tune_mhz, got.tune_mhz);
            cmp_field("cmd_guard_945", want.cmd_guard_945, got.cmd_guard_945);
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    in_word_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    out_word_t               m_data;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    lock_seq_scoreboard sb = new();
    bit calm;
    bit hold_req;
    int idle_cycles;

    demod_lock_acquisition_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #(ClkHalf) aclk = ~aclk;
    end

    // Result receiver: random stalls, plus one long counted hold-off on demand.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HoldCycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_report(m_data);
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("tb_demod_lock_acquisition_sequencer: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic in_word_t tick_word(logic auto_done, logic locked);
        in_word_t w;
        w               = in_word_t'($urandom);
        w.op            = OP_TICK;
        w.freq_khz      = FreqWidth'($urandom);
        w.auto_done     = auto_done;
        w.demod_locked  = locked;
        return w;
    endfunction

    function automatic in_word_t req_word(logic [FreqWidth-1:0] khz, logic force_play,
                                          logic guard_945);
        in_word_t w;
        w               = in_word_t'($urandom);
        w.op            = OP_REQUEST;
        w.freq_khz      = khz;
        w.force_play    = force_play;
        w.req_guard_945 = guard_945;
        return w;
    endfunction

    function automatic in_word_t rand_request();
        logic [FreqWidth-1:0] khz;
        case ($urandom_range(11))
            0:       khz = '0;
            1:       khz = '1;
            2:       khz = FreqWidth'(999);
            3:       khz = FreqWidth'(1000);
            default: khz = FreqWidth'($urandom);
        endcase
        return req_word(khz, 1'($urandom), 1'($urandom));
    endfunction

    // Offer one input word and hold it until accepted; valid stays high
    // afterwards unless the next word starts with a one-cycle gap.
    task automatic send_word(in_word_t w);
        if (!calm && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    // Stop sending and wait until every predicted word has come out.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // Write all registers back to back; optionally poke the spare index too.
    task automatic load_config(logic [2:0] aw, logic [1:0] gt, logic [2:0] mc,
                               logic [2:0] ut, bit poke_spare);
        logic [CfgIdxWidth-1:0]  idx[5];
        logic [CfgDataWidth-1:0] val[5];
        int n;
        idx = '{CFG_AUTO_WAIT_LIMIT, CFG_GUARD_TRIAL_LIMIT, CFG_MANUAL_CHECK_TICKS,
                CFG_UNLOCK_THRESHOLD, CfgSpareIdx};
        val = '{aw, {1'($urandom), gt}, mc, ut, CfgDataWidth'($urandom)};
        n = poke_spare ? 5 : 4;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random acquisition sessions: mostly a request followed by a run of
    // ticks whose lock behavior is drawn per session.
    task automatic run_sessions(int n_items, bit pause_midway);
        int sent;
        int ticks;
        int p_auto;
        int p_lock;
        bit paused;
        sent = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (pause_midway && !paused && sent >= n_items / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(9) != 0) begin
                send_word(rand_request());
                sent++;
                if ($urandom_range(7) == 0) begin
                    send_word(rand_request());
                    sent++;
                end
            end
            case ($urandom_range(3))
                0:       p_lock = 97;
                1:       p_lock = 75;
                2:       p_lock = 35;
                default: p_lock = 5;
            endcase
            p_auto = $urandom_range(20, 100);
            ticks  = $urandom_range(4, 40);
            repeat (ticks) begin
                send_word(tick_word($urandom_range(99) < p_auto,
                                    $urandom_range(99) < p_lock));
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under reset settings.
        // A tick before any request leaves the sequencer idle.
        send_word(tick_word(1'b1, 1'b1));
        // Scan at 0 kHz until the guard-interval trials run out.
        send_word(req_word('0, 1'b0, 1'b0));
        repeat (11) send_word(tick_word(1'b0, 1'b0));
        // Auto detection without lock keeps waiting; with lock goes manual.
        send_word(tick_word(1'b1, 1'b0));
        send_word(tick_word(1'b1, 1'b1));
        // A fully locked window reports lock.
        repeat (4) send_word(tick_word(1'b0, 1'b1));
        // Losing lock restarts checking; an unlocked tick in the window
        // sends the sequencer back to auto detection.
        send_word(tick_word(1'b0, 1'b0));
        send_word(tick_word(1'b0, 1'b0));
        repeat (3) send_word(tick_word(1'b1, 1'b1));
        // Two requests in a row: the later one, forced play at the top
        // frequency, is the one that starts.
        send_word(req_word(FreqWidth'(12345), 1'b0, 1'b0));
        send_word(req_word('1, 1'b1, 1'b1));
        send_word(tick_word(1'b0, 1'b1));
        run_sessions(150, 1'b0);
        drain();

        // Every limit at zero, with a long receiver hold-off.
        load_config(3'd0, 2'd0, 3'd0, 3'd0, 1'b0);
        hold_req = 1'b1;
        run_sessions(250, 1'b0);
        drain();

        // Every limit at its top, with no idling at all.
        load_config(3'd7, 2'd3, 3'd7, 3'd7, 1'b0);
        calm = 1'b1;
        run_sessions(250, 1'b0);
        drain();
        calm = 1'b0;

        // Short windows; the sender pauses halfway until all words are out.
        load_config(3'd1, 2'd1, 3'd1, 3'd0, 1'b0);
        run_sessions(250, 1'b1);
        drain();

        // Mixed extremes and a write to the spare index.
        load_config(3'd7, 2'd0, 3'd2, 3'd7, 1'b1);
        run_sessions(250, 1'b0);
        drain();

        // Random settings.
        load_config(3'($urandom), 2'($urandom), 3'($urandom), 3'($urandom), 1'b1);
        run_sessions(300, 1'b0);
        drain();

        repeat (2 * SettleCycles) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_demod_lock_acquisition_sequencer: done, clean");
        end else begin
            $display("tb_demod_lock_acquisition_sequencer: done, errors");
        end
        $finish;
    end

endmodule
